### rtl/assd_pkg.sv
// Shared types, constants and the segment decoder of the auto-ranging display.
package assd_pkg;

  localparam int unsigned VAL_W   = 17;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned EN_W    = 4;
  localparam int unsigned SLOT_W  = 2;

  localparam logic [KEY_W-1:0] KEY_TEMP  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_ANGLE = 4'd11;
  localparam logic [KEY_W-1:0] KEY_ROLL  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_PITCH = 4'd2;

  localparam logic [CNT_W-1:0] FLASH_TOP = 3'd5;
  localparam logic [CNT_W-1:0] FLASH_OFF = 3'd3;

  localparam logic [VAL_W-1:0] VALUE_MAX = 17'd99999;
  localparam logic [VAL_W-1:0] RANGE_HI  = 17'd10000;
  localparam logic [VAL_W-1:0] RANGE_MID = 17'd1000;

  // floor(v/100) = (v * RECIP_100) >> 24 for v <= 99999
  localparam logic [17:0] RECIP_100 = 18'd167773;
  // floor(v/10) = (v * RECIP_10) >> 17 for v < 10000
  localparam logic [13:0] RECIP_10  = 14'd13108;
  // narrow reciprocals for s < 1000
  localparam logic [5:0]  RECIP_S100 = 6'd41;
  localparam logic [7:0]  RECIP_S10  = 8'd205;

  localparam logic [SEG_W-1:0]  DEGREE_SEGS = 7'h63;
  localparam logic [SLOT_W-1:0] SLOT_LAST   = 2'd3;

  localparam logic [2:0] DOT_NONE  = 3'b000;
  localparam logic [2:0] DOT_SECND = 3'b010;
  localparam logic [2:0] DOT_FIRST = 3'b001;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [VAL_W-1:0] pitch;
    logic [VAL_W-1:0] roll;
    logic [VAL_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic               blank;
    logic [2:0]         dot_mask;
    logic [SCALE_W-1:0] scaled;
  } range_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/assd_front.sv
// Input register, flash/mode state, key dispatch and auto-ranging of the shown value.
module assd_front import assd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             rng_valid,
  input  logic             rng_ready,
  output range_t           rng
);

  logic             item_vld;
  in_item_t         item;
  logic [VAL_W-1:0] temp_limit;
  logic [CNT_W-1:0] flash_count;
  logic [CNT_W-1:0] flash_count_next;
  logic             angle_mode;
  logic             angle_mode_next;
  logic             lit;
  logic             emit;
  logic             blank;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] value_sat;
  logic [34:0]      prod_100;
  logic [27:0]      prod_10;
  range_t           rng_next;
  logic             rng_free;
  logic             advance;

  assign rng_free = !rng_valid || rng_ready;
  assign advance  = item_vld && rng_free;
  assign in_ready = !item_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_ready) begin
      item_vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit <= 17'd5000;
    end else if (cfg_wr_en) begin
      temp_limit <= cfg_wr_data;
    end
  end

  always_comb begin
    if (item.temperature < temp_limit) begin
      flash_count_next = '0;
    end else if (flash_count == FLASH_TOP) begin
      flash_count_next = '0;
    end else begin
      flash_count_next = flash_count + 3'd1;
    end
    lit = flash_count_next < FLASH_OFF;

    // first match wins
    emit            = 1'b0;
    blank           = 1'b0;
    value           = item.temperature;
    angle_mode_next = angle_mode;
    if (item.key_code == KEY_TEMP && lit) begin
      emit            = 1'b1;
      angle_mode_next = 1'b0;
    end else if (item.key_code == KEY_ANGLE) begin
      angle_mode_next = 1'b1;
    end else if (item.key_code == KEY_ROLL && angle_mode && lit) begin
      emit  = 1'b1;
      value = item.roll;
    end else if (item.key_code == KEY_PITCH && angle_mode && lit) begin
      emit  = 1'b1;
      value = item.pitch;
    end else if (!lit) begin
      emit  = 1'b1;
      blank = 1'b1;
    end
  end

  assign value_sat = (value > VALUE_MAX) ? VALUE_MAX : value;
  assign prod_100  = value_sat * RECIP_100;
  assign prod_10   = value_sat[13:0] * RECIP_10;

  always_comb begin
    rng_next.blank = blank;
    if (value_sat >= RANGE_HI) begin
      rng_next.scaled   = prod_100[33:24];
      rng_next.dot_mask = DOT_NONE;
    end else if (value_sat >= RANGE_MID) begin
      rng_next.scaled   = prod_10[26:17];
      rng_next.dot_mask = DOT_SECND;
    end else begin
      rng_next.scaled   = value_sat[SCALE_W-1:0];
      rng_next.dot_mask = DOT_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_valid   <= 1'b0;
      flash_count <= '0;
      angle_mode  <= 1'b0;
    end else begin
      if (rng_free) begin
        rng_valid <= advance && emit;
      end
      if (advance) begin
        flash_count <= flash_count_next;
        angle_mode  <= angle_mode_next;
      end
    end
    if (advance) begin
      rng <= rng_next;
    end
  end

endmodule

### rtl/assd_frame.sv
// Digit split, segment decode and the four-slot frame register that drives the output.
module assd_frame import assd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rng_valid,
  output logic        rng_ready,
  input  range_t      rng,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  digit_enable,
  output logic [6:0]  segments,
  output logic        dot,
  output logic        last
);

  logic [15:0]        prod_d0;
  logic [17:0]        prod_t;
  logic [DIG_W-1:0]   d0;
  logic [6:0]         tens;
  logic [DIG_W-1:0]   d1;
  logic [DIG_W-1:0]   d2;
  logic               busy;
  logic [SLOT_W-1:0]  slot;
  logic               blank_r;
  logic [2:0]         dot_r;
  logic [SEG_W-1:0]   seg_r [3];
  logic               load;
  logic               send;

  // hundreds and tens in parallel, then the remainders
  assign prod_d0 = rng.scaled * RECIP_S100;
  assign prod_t  = rng.scaled * RECIP_S10;
  assign d0      = prod_d0[15:12];
  assign tens    = prod_t[17:11];
  assign d1      = DIG_W'(tens - 7'(d0) * 7'd10);
  assign d2      = DIG_W'(rng.scaled - 10'(tens) * 10'd10);

  assign send      = busy && out_ready;
  assign rng_ready = !busy || (out_ready && slot == SLOT_LAST);
  assign load      = rng_valid && rng_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (send && slot == SLOT_LAST) begin
        busy <= 1'b0;
      end
      if (send) begin
        slot <= slot + 2'd1;
      end
    end
    if (load) begin
      blank_r  <= rng.blank;
      dot_r    <= rng.dot_mask;
      seg_r[0] <= seg_of(d0);
      seg_r[1] <= seg_of(d1);
      seg_r[2] <= seg_of(d2);
    end
  end

  always_comb begin
    digit_enable = '0;
    segments     = '0;
    dot          = 1'b0;
    if (!blank_r) begin
      digit_enable = EN_W'(1) << slot;
      case (slot)
        2'd0:    begin segments = seg_r[0]; dot = dot_r[0]; end
        2'd1:    begin segments = seg_r[1]; dot = dot_r[1]; end
        2'd2:    begin segments = seg_r[2]; dot = dot_r[2]; end
        default: begin segments = DEGREE_SEGS; dot = 1'b0; end
      endcase
    end
  end

  assign out_valid = busy;
  assign last      = slot == SLOT_LAST;

`ifndef SYNTH
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_enable != 4'd0 |-> $onehot(digit_enable))
    else $error("digit enable not one-hot");

  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_enable == 4'd0 |-> segments == 7'd0 && !dot)
    else $error("blank slot shows segments");

  a_degree_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !blank_r |-> segments == DEGREE_SEGS && !dot)
    else $error("fourth slot is not the degree symbol");

  a_frame_whole: assert property (@(posedge clk) disable iff (rst)
    send && !last |=> out_valid && slot == $past(slot) + 2'd1)
    else $error("frame broken before its fourth slot");
`endif

endmodule

### rtl/autorange_seven_segment_display_top.sv
// Top level of the auto-ranging four-digit seven-segment display controller.
//
//  channel  direction  handshake                      payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata: temperature, roll, pitch; tuser: key
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata: digit_enable, segments, dot; tlast
//  cfg      in         cfg_wr_en (no wait)            cfg_wr_data: temp_limit
//
// An item that shows a value or a blank frame yields four slot items, one per cycle while
// m_axis_tready is high, set by the slot counter; the frame register takes the next range
// only as the last slot goes out. Items that yield nothing are taken at one per cycle while
// the range register is free. An item passes the input and range registers before the frame
// register. Reset (rst, synchronous) clears flash count, angle mode and sets temp_limit to
// 5000. A stalled output holds the slot; the input and range registers accept until full.
module autorange_seven_segment_display_top import assd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,   // temp_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // [16:0] temperature, [33:17] roll, [50:34] pitch
  input  logic [3:0]  s_axis_tuser,  // [3:0] key_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] digit_enable, [10:4] segments, [11] dot
  output logic        m_axis_tlast
);

  in_item_t   in_item;
  range_t     rng;
  logic       rng_valid;
  logic       rng_ready;
  logic [3:0] digit_enable;
  logic [6:0] segments;
  logic       dot;

  assign in_item.temperature = s_axis_tdata[16:0];
  assign in_item.roll        = s_axis_tdata[33:17];
  assign in_item.pitch       = s_axis_tdata[50:34];
  assign in_item.key_code    = s_axis_tuser;

  assd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .rng_valid   (rng_valid),
    .rng_ready   (rng_ready),
    .rng         (rng)
  );

  assd_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .rng_valid    (rng_valid),
    .rng_ready    (rng_ready),
    .rng          (rng),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .digit_enable (digit_enable),
    .segments     (segments),
    .dot          (dot),
    .last         (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, dot, segments, digit_enable};

endmodule
